/* hdl/pie_pulse_width_decoder_defines.svh */
// Assertion macros used by the checker file
`ifndef PIE_PULSE_WIDTH_DECODER_DEFINES_SVH
`define PIE_PULSE_WIDTH_DECODER_DEFINES_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define PIEDEC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define PIEDEC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/piedec_pkg.sv */
`timescale 1ns / 1ps

package piedec_pkg;

   localparam int LenW   = 16;
   localparam int CfgW   = 16;
   localparam int CountW = 8;
   localparam int PhaseW = 3;
   localparam int IndexW = 3;
   localparam int ExpW   = 19;
   localparam int WinW   = 24;

   localparam int MaxBitsDefault = 255;

   localparam logic [CfgW-1:0] DelimReset = 16'd25;
   localparam logic [CfgW-1:0] PwReset    = 16'd25;
   localparam logic [CfgW-1:0] RtcalReset = 16'd150;
   localparam logic [CfgW-1:0] TrcalReset = 16'd400;
   localparam logic            ModeReset  = 1'b1;

   localparam logic [IndexW-1:0] RegDelim = 3'd0;
   localparam logic [IndexW-1:0] RegPw    = 3'd1;
   localparam logic [IndexW-1:0] RegRtcal = 3'd2;
   localparam logic [IndexW-1:0] RegTrcal = 3'd3;
   localparam logic [IndexW-1:0] RegMode  = 3'd4;

   typedef enum logic [PhaseW-1:0] {
      PH_DELIM = 3'd0,
      PH_DATA0 = 3'd1,
      PH_RTCAL = 3'd2,
      PH_TRCAL = 3'd3,
      PH_DATAS = 3'd4
   } piedec_phase_type;

   typedef struct packed {
      logic signed [WinW-1:0] lo;
      logic signed [WinW-1:0] hi;
   } piedec_win_type;

   typedef struct packed {
      piedec_win_type delim;
      piedec_win_type pw;
      piedec_win_type pw3;
      piedec_win_type rtcal;
      piedec_win_type trcal;
      logic           preamble;
   } piedec_bounds_type;

   typedef struct packed {
      piedec_phase_type   phase;
      logic               expect_high;
      logic               pending_bit;
      logic [CountW-1:0]  bits_decoded;
   } piedec_state_type;

   typedef struct packed {
      logic [CountW-1:0] bit_count;
      logic              bit_valid;
      logic              bit_value;
      logic              decoder_reset;
      logic [PhaseW-1:0] frame_phase;
   } piedec_result_type;

   localparam piedec_state_type StateReset = '{
      phase:        PH_DELIM,
      expect_high:  1'b0,
      pending_bit:  1'b0,
      bits_decoded: '0
   };

   // window bounds 9*e and 11*e
   function automatic piedec_win_type make_win(input logic signed [ExpW-1:0] e);
      logic signed [WinW-1:0] ex;
      piedec_win_type w;
      ex   = WinW'(e);
      w.lo = (ex <<< 3) + ex;
      w.hi = (ex <<< 3) + (ex <<< 1) + ex;
      return w;
   endfunction

   function automatic logic in_win(input piedec_win_type w,
                                   input logic signed [WinW-1:0] t);
      return (w.lo <= t) && (t <= w.hi);
   endfunction

endpackage

/* hdl/piedec_csr.sv */
`timescale 1ns / 1ps

module piedec_csr
   import piedec_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [IndexW-1:0]      csr_index,
   input  logic [CfgW-1:0]        csr_wdata,
   output piedec_bounds_type      bounds
);

   logic [CfgW-1:0]   delim_ff;
   logic [CfgW-1:0]   pw_ff;
   logic [CfgW-1:0]   rtcal_ff;
   logic [CfgW-1:0]   trcal_ff;
   logic              mode_ff;
   piedec_bounds_type bounds_ff;
   piedec_bounds_type bounds_in;

   logic signed [ExpW-1:0] exp_delim;
   logic signed [ExpW-1:0] exp_pw;
   logic signed [ExpW-1:0] exp_pw3;
   logic signed [ExpW-1:0] exp_rtcal;
   logic signed [ExpW-1:0] exp_trcal;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= DelimReset;
         pw_ff    <= PwReset;
         rtcal_ff <= RtcalReset;
         trcal_ff <= TrcalReset;
         mode_ff  <= ModeReset;
      end else if (csr_we) begin
         case (csr_index)
            RegDelim: delim_ff <= csr_wdata;
            RegPw:    pw_ff    <= csr_wdata;
            RegRtcal: rtcal_ff <= csr_wdata;
            RegTrcal: trcal_ff <= csr_wdata;
            RegMode:  mode_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      exp_delim = signed'({3'b000, delim_ff});
      exp_pw    = signed'({3'b000, pw_ff});
      exp_pw3   = signed'({2'b00, pw_ff, 1'b0}) + signed'({3'b000, pw_ff});
      exp_rtcal = signed'({3'b000, rtcal_ff}) - exp_pw;
      exp_trcal = signed'({3'b000, trcal_ff}) - exp_pw;

      bounds_in.delim    = make_win(exp_delim);
      bounds_in.pw       = make_win(exp_pw);
      bounds_in.pw3      = make_win(exp_pw3);
      bounds_in.rtcal    = make_win(exp_rtcal);
      bounds_in.trcal    = make_win(exp_trcal);
      bounds_in.preamble = mode_ff;
   end

   // window registers: refresh every cycle
   always_ff @(posedge clock) begin
      bounds_ff <= bounds_in;
   end

   assign bounds = bounds_ff;

endmodule

/* hdl/piedec_step.sv */
`timescale 1ns / 1ps

module piedec_step
   import piedec_pkg::*;
#(
   parameter int MAX_BITS = MaxBitsDefault
)
(
   input  piedec_bounds_type  bounds,
   input  logic               is_low,
   input  logic [LenW-1:0]    duration,
   input  piedec_state_type   cur,
   output piedec_state_type   nxt,
   output piedec_result_type  result
);

   localparam logic [CountW-1:0] CountLimit =
      (MAX_BITS < 255) ? CountW'(MAX_BITS) : CountW'(255);

   logic signed [WinW-1:0] ten_len;
   logic ok_delim;
   logic ok_pw;
   logic ok_pw3;
   logic ok_rtcal;
   logic ok_trcal;
   logic ok_low;
   logic valid;
   logic value;
   logic did_reset;

   always_comb begin
      ten_len  = signed'({5'b0, duration, 3'b000}) + signed'({7'b0, duration, 1'b0});
      ok_delim = in_win(bounds.delim, ten_len);
      ok_pw    = in_win(bounds.pw, ten_len);
      ok_pw3   = in_win(bounds.pw3, ten_len);
      ok_rtcal = in_win(bounds.rtcal, ten_len);
      ok_trcal = in_win(bounds.trcal, ten_len);
      ok_low   = (cur.phase == PH_DELIM) ? ok_delim : ok_pw;
   end

   always_comb begin
      nxt       = cur;
      valid     = 1'b0;
      value     = 1'b0;
      did_reset = 1'b0;

      if (!is_low) begin
         if (!cur.expect_high) begin
            nxt       = StateReset;
            did_reset = 1'b1;
         end else begin
            nxt.expect_high = 1'b0;
            case (cur.phase)
               PH_DATAS: begin
                  if (ok_pw) begin
                     nxt.pending_bit = 1'b0;
                  end else if (ok_pw3) begin
                     nxt.pending_bit = 1'b1;
                  end else begin
                     nxt       = StateReset;
                     did_reset = 1'b1;
                  end
               end
               PH_DATA0: begin
                  if (!ok_pw) begin
                     nxt       = StateReset;
                     did_reset = 1'b1;
                  end
               end
               PH_RTCAL: begin
                  if (!ok_rtcal) begin
                     nxt       = StateReset;
                     did_reset = 1'b1;
                  end
               end
               PH_TRCAL: begin
                  if (!ok_trcal) begin
                     nxt       = StateReset;
                     did_reset = 1'b1;
                  end
               end
               default: begin
                  nxt       = StateReset;
                  did_reset = 1'b1;
               end
            endcase
         end
      end else begin
         if (cur.expect_high) begin
            nxt       = StateReset;
            did_reset = 1'b1;
         end else if (cur.phase == PH_DATAS) begin
            nxt.expect_high = 1'b1;
            if (ok_pw) begin
               valid = 1'b1;
               value = cur.pending_bit;
               if (cur.bits_decoded < CountLimit) begin
                  nxt.bits_decoded = cur.bits_decoded + CountW'(1);
               end
            end else begin
               nxt       = StateReset;
               did_reset = 1'b1;
            end
         end else if (ok_low) begin
            nxt.expect_high = 1'b1;
            case (cur.phase)
               PH_DELIM: nxt.phase = PH_DATA0;
               PH_DATA0: nxt.phase = PH_RTCAL;
               PH_RTCAL: nxt.phase = bounds.preamble ? PH_TRCAL : PH_DATAS;
               default:  nxt.phase = PH_DATAS;
            endcase
         end else begin
            // drop the frame, retry the low as a delimiter outside delimiter phase
            nxt       = StateReset;
            did_reset = 1'b1;
            if ((cur.phase != PH_DELIM) && ok_delim) begin
               nxt.expect_high = 1'b1;
               nxt.phase       = PH_DATA0;
            end
         end
      end

      result.bit_count     = nxt.bits_decoded;
      result.bit_valid     = valid;
      result.bit_value     = value;
      result.decoder_reset = did_reset;
      result.frame_phase   = PhaseW'(nxt.phase);
   end

endmodule

/* hdl/pie_pulse_width_decoder.sv */
`timescale 1ns / 1ps
// An accepted request is held in the input register, decoded, and stored in the result register.
// Throughput: one request per cycle while results are taken, set by the single decode step between the two registers.
// Reset (synchronous): decoder returns to delimiter phase, count cleared, registers to defaults.
// A register write takes effect on requests accepted from the following cycle on.
module pie_pulse_width_decoder
   import piedec_pkg::*;
#(
   parameter int MAX_BITS = MaxBitsDefault
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [IndexW-1:0]   csr_index,
   input  logic [CfgW-1:0]     csr_wdata,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   input  logic [LenW-1:0]     req_duration,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CountW-1:0]   rsp_bit_count,
   output logic                rsp_bit_valid,
   output logic                rsp_bit_value,
   output logic                rsp_decoder_reset,
   output logic [PhaseW-1:0]   rsp_frame_phase
);

   piedec_bounds_type bounds;

   logic              s1_valid_ff;
   logic              s1_type_ff;
   logic [LenW-1:0]   s1_len_ff;
   logic              rsp_valid_ff;
   piedec_result_type result_ff;
   piedec_result_type result_in;
   piedec_state_type  state_ff;
   piedec_state_type  state_in;
   logic              advance;

   piedec_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .bounds    (bounds)
   );

   piedec_step #(
      .MAX_BITS (MAX_BITS)
   ) u_step (
      .bounds    (bounds),
      .is_low    (s1_type_ff),
      .duration  (s1_len_ff),
      .cur       (state_ff),
      .nxt       (state_in),
      .result    (result_in)
   );

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= StateReset;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
            if (s1_valid_ff) begin
               state_ff <= state_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_type_ff <= req_type;
         s1_len_ff  <= req_duration;
      end
      if (advance && s1_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bit_count     = result_ff.bit_count;
   assign rsp_bit_valid     = result_ff.bit_valid;
   assign rsp_bit_value     = result_ff.bit_value;
   assign rsp_decoder_reset = result_ff.decoder_reset;
   assign rsp_frame_phase   = result_ff.frame_phase;

endmodule

/* hdl/piedec_checker.sv */
`timescale 1ns / 1ps
`include "pie_pulse_width_decoder_defines.svh"

module piedec_checker
   import piedec_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [IndexW-1:0]   csr_index,
   input  logic [CfgW-1:0]     csr_wdata,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_type,
   input  logic [LenW-1:0]     req_duration,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [CountW-1:0]   rsp_bit_count,
   input  logic                rsp_bit_valid,
   input  logic                rsp_bit_value,
   input  logic                rsp_decoder_reset,
   input  logic [PhaseW-1:0]   rsp_frame_phase
);

   `PIEDEC_ASSERT_NOW(a_bit_in_data, rsp_valid && rsp_bit_valid,
      !rsp_decoder_reset && rsp_frame_phase == PH_DATAS,
      "bit committed outside data phase or with reset")
   `PIEDEC_ASSERT_NOW(a_reset_clears, rsp_valid && rsp_decoder_reset,
      rsp_bit_count == '0, "decoder reset left a non-zero bit count")
   `PIEDEC_ASSERT_NOW(a_value_needs_valid, rsp_valid && rsp_bit_value,
      rsp_bit_valid, "bit value set without a committed bit")
   `PIEDEC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_bit_count) && $stable(rsp_frame_phase),
      "stalled result changed")
   `PIEDEC_ASSERT_NOW(a_empty_after_reset, $past(reset), !rsp_valid,
      "result valid straight after reset")

endmodule

bind pie_pulse_width_decoder piedec_checker u_piedec_checker (.*);

/* tb/pie_pulse_width_decoder_check.sv */
`timescale 1ns / 1ps

module pie_pulse_width_decoder_check
   import piedec_pkg::*;
#(
   parameter int MaxBits = MaxBitsDefault
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [IndexW-1:0]   csr_index,
   input  logic [CfgW-1:0]     csr_wdata,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_type,
   input  logic [LenW-1:0]     req_duration,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [CountW-1:0]   rsp_bit_count,
   input  logic                rsp_bit_valid,
   input  logic                rsp_bit_value,
   input  logic                rsp_decoder_reset,
   input  logic [PhaseW-1:0]   rsp_frame_phase,
   output int                  fail_count,
   output int                  outstanding,
   output int                  checked_count
);

   localparam int CountLimit = (MaxBits < 255) ? MaxBits : 255;

   logic [CfgW-1:0]   cfg_delim;
   logic [CfgW-1:0]   cfg_pw;
   logic [CfgW-1:0]   cfg_rtcal;
   logic [CfgW-1:0]   cfg_trcal;
   logic              cfg_mode;

   piedec_phase_type  dec_phase;
   logic              dec_expect_high;
   logic              dec_pending;
   logic [CountW-1:0] dec_count;

   piedec_result_type predicted_pulses [$];

   function automatic bit in_window(input longint len, input longint e);
      return (9 * e <= 10 * len) && (10 * len <= 11 * e);
   endfunction

   function automatic void clear_decoder();
      dec_phase       = PH_DELIM;
      dec_expect_high = 1'b0;
      dec_pending     = 1'b0;
      dec_count       = '0;
   endfunction

   function automatic piedec_result_type decode_pulse(input logic is_low,
                                                      input logic [LenW-1:0] len_in);
      longint            len;
      longint            pw;
      longint            e;
      logic              committed;
      logic              value;
      logic              cleared;
      piedec_result_type r;
      len       = longint'(len_in);
      pw        = longint'(cfg_pw);
      committed = 1'b0;
      value     = 1'b0;
      cleared   = 1'b0;
      if (!is_low) begin
         if (!dec_expect_high) begin
            clear_decoder();
            cleared = 1'b1;
         end else begin
            dec_expect_high = 1'b0;
            if (dec_phase == PH_DATAS) begin
               if (in_window(len, pw)) begin
                  dec_pending = 1'b0;
               end else if (in_window(len, 3 * pw)) begin
                  dec_pending = 1'b1;
               end else begin
                  clear_decoder();
                  cleared = 1'b1;
               end
            end else if (dec_phase == PH_DELIM) begin
               clear_decoder();
               cleared = 1'b1;
            end else begin
               if (dec_phase == PH_DATA0) begin
                  e = pw;
               end else if (dec_phase == PH_RTCAL) begin
                  e = longint'(cfg_rtcal) - pw;
               end else begin
                  e = longint'(cfg_trcal) - pw;
               end
               if (!in_window(len, e)) begin
                  clear_decoder();
                  cleared = 1'b1;
               end
            end
         end
      end else begin
         if (dec_expect_high) begin
            clear_decoder();
            cleared = 1'b1;
         end else begin
            dec_expect_high = 1'b1;
            if (dec_phase == PH_DATAS) begin
               if (in_window(len, pw)) begin
                  committed = 1'b1;
                  value     = dec_pending;
                  if (dec_count < CountLimit) dec_count = dec_count + 1'b1;
               end else begin
                  clear_decoder();
                  cleared = 1'b1;
               end
            end else begin
               e = (dec_phase == PH_DELIM) ? longint'(cfg_delim) : pw;
               if (in_window(len, e)) begin
                  if (dec_phase == PH_DELIM) begin
                     dec_phase = PH_DATA0;
                  end else if (dec_phase == PH_DATA0) begin
                     dec_phase = PH_RTCAL;
                  end else if (dec_phase == PH_RTCAL) begin
                     if (cfg_mode) dec_phase = PH_TRCAL;
                     else dec_phase = PH_DATAS;
                  end else begin
                     dec_phase = PH_DATAS;
                  end
               end else if (dec_phase == PH_DELIM) begin
                  clear_decoder();
                  cleared = 1'b1;
               end else begin
                  // drop the frame, then retry the same low as a delimiter
                  clear_decoder();
                  cleared = 1'b1;
                  if (in_window(len, longint'(cfg_delim))) begin
                     dec_phase       = PH_DATA0;
                     dec_expect_high = 1'b1;
                  end
               end
            end
         end
      end
      r.bit_count     = dec_count;
      r.bit_valid     = committed;
      r.bit_value     = value;
      r.decoder_reset = cleared;
      r.frame_phase   = dec_phase;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      piedec_result_type want;
      piedec_result_type fresh;
      if (reset) begin
         cfg_delim     = DelimReset;
         cfg_pw        = PwReset;
         cfg_rtcal     = RtcalReset;
         cfg_trcal     = TrcalReset;
         cfg_mode      = ModeReset;
         clear_decoder();
         predicted_pulses.delete();
         fail_count    = 0;
         checked_count = 0;
      end else begin
         if (req_valid && req_ready) begin
            fresh            = decode_pulse(req_type, req_duration);
            predicted_pulses = {predicted_pulses, fresh};
         end
         if (csr_we) begin
            case (csr_index)
               RegDelim: cfg_delim = csr_wdata;
               RegPw:    cfg_pw    = csr_wdata;
               RegRtcal: cfg_rtcal = csr_wdata;
               RegTrcal: cfg_trcal = csr_wdata;
               RegMode:  cfg_mode  = csr_wdata[0];
               default:  ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_pulses.size() == 0) begin
               report_mismatch("result with no request", 0, 1);
            end else begin
               want = predicted_pulses.pop_front();
               checked_count++;
               if (rsp_bit_count !== want.bit_count)
                  report_mismatch("bit_count", want.bit_count, rsp_bit_count);
               if (rsp_bit_valid !== want.bit_valid)
                  report_mismatch("bit_valid", want.bit_valid, rsp_bit_valid);
               if (rsp_bit_value !== want.bit_value)
                  report_mismatch("bit_value", want.bit_value, rsp_bit_value);
               if (rsp_decoder_reset !== want.decoder_reset)
                  report_mismatch("decoder_reset", want.decoder_reset, rsp_decoder_reset);
               if (rsp_frame_phase !== want.frame_phase)
                  report_mismatch("frame_phase", want.frame_phase, rsp_frame_phase);
            end
         end
      end
      outstanding = predicted_pulses.size();
   end

endmodule

/* tb/pie_pulse_width_decoder_tb.sv */
`timescale 1ns / 1ps

module pie_pulse_width_decoder_tb;
   import piedec_pkg::*;

   localparam int CycleLimit  = 500000;
   localparam int StallCycles = 300;
   localparam int PlanMax     = 1024;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   logic [IndexW-1:0]   csr_index;
   logic [CfgW-1:0]     csr_wdata;
   logic                req_valid;
   logic                req_ready;
   logic                req_type;
   logic [LenW-1:0]     req_duration;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [CountW-1:0]   rsp_bit_count;
   logic                rsp_bit_valid;
   logic                rsp_bit_value;
   logic                rsp_decoder_reset;
   logic [PhaseW-1:0]   rsp_frame_phase;

   int                  fail_count;
   int                  outstanding;
   int                  checked_count;

   logic [CfgW-1:0]     cfg_delim = DelimReset;
   logic [CfgW-1:0]     cfg_pw    = PwReset;
   logic [CfgW-1:0]     cfg_rtcal = RtcalReset;
   logic [CfgW-1:0]     cfg_trcal = TrcalReset;
   logic                cfg_mode  = ModeReset;

   bit                  idle_on = 1'b1;
   bit                  stall_request = 1'b0;
   int                  pulses_sent = 0;
   int                  phase_items = 0;
   int                  settings_used = 1;
   int                  cycle_count = 0;

   logic                plan_low   [PlanMax];
   longint              plan_exp   [PlanMax];
   bit                  plan_retry [PlanMax];
   int                  plan_size;

   pie_pulse_width_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_duration      (req_duration),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_bit_count     (rsp_bit_count),
      .rsp_bit_valid     (rsp_bit_valid),
      .rsp_bit_value     (rsp_bit_value),
      .rsp_decoder_reset (rsp_decoder_reset),
      .rsp_frame_phase   (rsp_frame_phase)
   );

   pie_pulse_width_decoder_check u_check (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_duration      (req_duration),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_bit_count     (rsp_bit_count),
      .rsp_bit_valid     (rsp_bit_valid),
      .rsp_bit_value     (rsp_bit_value),
      .rsp_decoder_reset (rsp_decoder_reset),
      .rsp_frame_phase   (rsp_frame_phase),
      .fail_count        (fail_count),
      .outstanding       (outstanding),
      .checked_count     (checked_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
         $display("pie_pulse_width_decoder regression: fail");
         $finish;
      end
   end

   function automatic int idle_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(99, 0);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic logic [LenW-1:0] any_len();
      if ($urandom_range(1, 0) != 0) return LenW'($urandom);
      return LenW'($urandom_range(300, 0));
   endfunction

   function automatic logic [LenW-1:0] len_near(input longint e);
      longint lo;
      longint hi;
      if (e < 0) return any_len();
      lo = (9 * e + 9) / 10;
      hi = (11 * e) / 10;
      if (hi > 65535) hi = 65535;
      if (lo > hi) return any_len();
      case ($urandom_range(3, 0))
         0:       return LenW'(lo);
         1:       return LenW'(hi);
         default: return LenW'($urandom_range(int'(hi), int'(lo)));
      endcase
   endfunction

   function automatic logic [LenW-1:0] len_off(input longint e);
      longint lo;
      longint hi;
      if (e < 0) return any_len();
      lo = (9 * e + 9) / 10;
      hi = (11 * e) / 10;
      if ($urandom_range(1, 0) != 0 && lo > 0) return LenW'(lo - 1);
      if (hi < 65535) return LenW'(hi + 1);
      if (lo > 0) return LenW'(lo - 1);
      return any_len();
   endfunction

   function automatic void add_step(input logic lowp, input longint e, input bit retry);
      plan_low[plan_size]   = lowp;
      plan_exp[plan_size]   = e;
      plan_retry[plan_size] = retry;
      plan_size++;
   endfunction

   task automatic send_pulse(input logic is_low, input logic [LenW-1:0] len);
      int gap;
      req_valid    <= 1'b1;
      req_type     <= is_low;
      req_duration <= len;
      // hold the request until the block takes it
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pulses_sent++;
      phase_items++;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [IndexW-1:0] idx, input logic [CfgW-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         RegDelim: cfg_delim = val;
         RegPw:    cfg_pw    = val;
         RegRtcal: cfg_rtcal = val;
         RegTrcal: cfg_trcal = val;
         RegMode:  cfg_mode  = val[0];
         default:  ;
      endcase
   endtask

   task automatic load_config(input logic [CfgW-1:0] d, input logic [CfgW-1:0] p,
                              input logic [CfgW-1:0] r, input logic [CfgW-1:0] t,
                              input logic m);
      wait_idle();
      write_reg(RegDelim, d);
      write_reg(RegPw, p);
      write_reg(RegRtcal, r);
      write_reg(RegTrcal, t);
      write_reg(RegMode, {{(CfgW-1){1'b0}}, m});
      csr_we <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   task automatic send_frame(input int nbits, input bit spoil);
      int              bad_at;
      int              how;
      longint          pw;
      logic            lowp;
      logic [LenW-1:0] len;
      pw        = longint'(cfg_pw);
      plan_size = 0;
      // two highs land the decoder in the delimiter phase from any state
      add_step(1'b0, -1, 1'b0);
      add_step(1'b0, -1, 1'b0);
      add_step(1'b1, longint'(cfg_delim), 1'b0);
      add_step(1'b0, pw, 1'b0);
      add_step(1'b1, pw, 1'b1);
      add_step(1'b0, longint'(cfg_rtcal) - pw, 1'b0);
      add_step(1'b1, pw, 1'b1);
      if (cfg_mode) begin
         add_step(1'b0, longint'(cfg_trcal) - pw, 1'b0);
         add_step(1'b1, pw, 1'b1);
      end
      for (int i = 0; i < nbits; i++) begin
         add_step(1'b0, ($urandom_range(1, 0) != 0) ? 3 * pw : pw, 1'b0);
         add_step(1'b1, pw, 1'b0);
      end
      bad_at = spoil ? $urandom_range(plan_size - 1, 2) : -1;
      how    = $urandom_range(2, 0);
      for (int i = 0; i < plan_size; i++) begin
         lowp = plan_low[i];
         len  = len_near(plan_exp[i]);
         if (i == bad_at) begin
            if (how == 0) len = len_off(plan_exp[i]);
            else if (how == 1) lowp = !lowp;
            else if (plan_retry[i]) len = len_near(longint'(cfg_delim));
            else len = len_off(plan_exp[i]);
         end
         send_pulse(lowp, len);
      end
   endtask

   task automatic send_noise();
      longint e;
      case ($urandom_range(5, 0))
         0:       e = longint'(cfg_delim);
         1:       e = longint'(cfg_pw);
         2:       e = 3 * longint'(cfg_pw);
         3:       e = longint'(cfg_rtcal) - longint'(cfg_pw);
         4:       e = longint'(cfg_trcal) - longint'(cfg_pw);
         default: e = -1;
      endcase
      send_pulse(1'($urandom_range(1, 0)), len_near(e));
   endtask

   task automatic run_random(input int budget);
      phase_items = 0;
      while (phase_items < budget) begin
         idle_on = ($urandom_range(4, 0) != 0);
         if ($urandom_range(9, 0) == 0) begin
            repeat ($urandom_range(4, 1)) send_noise();
         end else begin
            send_frame($urandom_range(10, 0), $urandom_range(3, 0) == 0);
         end
      end
      idle_on = 1'b1;
   endtask

   task automatic load_random_config();
      int p;
      int r;
      int t;
      p = $urandom_range(5000, 1);
      r = p + $urandom_range(20000, 0);
      if ($urandom_range(3, 0) == 0) r = $urandom_range(65535, 1);
      if (r > 65535) r = 65535;
      t = r + $urandom_range(20000, 0);
      if (t > 65535) t = 65535;
      load_config(CfgW'($urandom_range(65535, 1)), CfgW'(p), CfgW'(r), CfgW'(t),
                  1'($urandom_range(1, 0)));
   endtask

   initial begin : receiver
      int run;
      int stall;
      rsp_ready <= 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (stall_request) begin
            rsp_ready <= 1'b0;
            repeat (StallCycles) @(posedge clock);
            stall_request = 1'b0;
         end else begin
            run   = idle_on ? $urandom_range(8, 1) : 16;
            stall = idle_gap();
            rsp_ready <= 1'b1;
            repeat (run) @(posedge clock);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      reset        <= 1'b1;
      csr_we       <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      req_valid    <= 1'b0;
      req_type     <= 1'b0;
      req_duration <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values: edges of each window and the special cases
      send_pulse(1'b0, 16'd25);
      send_pulse(1'b1, 16'd0);
      send_pulse(1'b1, 16'd65535);
      send_pulse(1'b1, 16'd23);
      send_pulse(1'b1, 16'd25);
      send_pulse(1'b1, 16'd27);
      send_pulse(1'b0, 16'd25);
      send_pulse(1'b1, 16'd25);
      send_pulse(1'b0, 16'd125);
      send_pulse(1'b1, 16'd200);
      send_pulse(1'b1, 16'd25);
      send_pulse(1'b0, 16'd28);
      send_pulse(1'b1, 16'd25);
      send_pulse(1'b0, 16'd23);
      send_pulse(1'b1, 16'd27);
      send_pulse(1'b0, 16'd113);
      send_pulse(1'b1, 16'd25);
      send_pulse(1'b0, 16'd412);
      send_pulse(1'b1, 16'd23);
      send_pulse(1'b0, 16'd25);
      send_pulse(1'b1, 16'd25);
      send_pulse(1'b0, 16'd75);
      send_pulse(1'b1, 16'd27);
      send_pulse(1'b0, 16'd50);
      run_random(60);

      // short pulses, frame sync, one frame long enough to saturate the count
      load_config(16'd12, 16'd6, 16'd18, 16'd40, 1'b0);
      send_frame(260, 1'b0);
      run_random(60);

      // zero expected RTCAL high; hold off the receiver while requests keep coming
      load_config(16'd1, 16'd1, 16'd1, 16'd65535, 1'b1);
      idle_on       = 1'b0;
      stall_request = 1'b1;
      send_frame(20, 1'b0);
      idle_on       = 1'b1;
      run_random(60);

      load_config(16'd65535, 16'd21845, 16'd65535, 16'd65535, 1'b0);
      run_random(60);

      // RTCAL and TRCAL shorter than PW
      load_config(16'd40, 16'd30, 16'd20, 16'd10, 1'b1);
      run_random(60);

      load_random_config();
      run_random(60);
      load_random_config();
      run_random(60);

      wait_idle();
      repeat (8) @(posedge clock);
      $display("%0d pulses over %0d register settings, %0d results compared, %0d mismatches",
               pulses_sent, settings_used, checked_count, fail_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("pie_pulse_width_decoder regression: pass");
      end else begin
         $display("pie_pulse_width_decoder regression: fail");
      end
      $finish;
   end

endmodule
